// ===== src/encoder_speed_rpm_filter_macros.svh =====
// Assertion macros shared by the verification files of the speed filter.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef ENCODER_SPEED_RPM_FILTER_MACROS_SVH
`define ENCODER_SPEED_RPM_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("speed filter check failed");

// Consequent must hold in the cycle after the antecedent.
`define ESRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("speed filter check failed");

// As above but also checked while reset is asserted.
`define ESRF_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("speed filter reset check failed");

`endif

// ===== src/esrf_pkg.sv =====
// Package for the encoder speed filter: widths, constants and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package esrf_pkg;

  localparam int COUNTER_BITS_DEF = 16;

  localparam int PER_W      = 10;
  localparam int PPR_W      = 13;
  localparam int DEN_W      = PER_W + PPR_W;
  localparam int SCALE_W    = 24;
  localparam int RPM_W      = 40;
  localparam int OPND_W     = RPM_W + 1;
  localparam int COEF_W     = 15;
  localparam int PROD_W     = OPND_W + COEF_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_BITS  = 15;
  localparam int SH_W       = ACC_W - FRAC_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PPR_W;

  // 60 s/min * 1000 ms/s * 256 sub-RPM steps.
  localparam logic [SCALE_W-1:0] SCALE = 24'd15360000;

  localparam logic signed [RPM_W-1:0] RPM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [RPM_W-1:0] RPM_MIN = 40'sh80_0000_0000;

  // Signed 15-bit taps scaled by 2^-15 (Q0.15): 0.3859 on new and previous raw, 0.2283 on feedback.
  localparam logic signed [COEF_W-1:0] COEF_NEW = 15'sd12645;
  localparam logic signed [COEF_W-1:0] COEF_FB  = 15'sd7481;

  // Half an LSB, and one less for negative sums: ties round away from zero.
  localparam logic signed [ACC_W-1:0] RND_POS = 57'sd16384;
  localparam logic signed [ACC_W-1:0] RND_NEG = 57'sd16383;

  localparam logic [PER_W-1:0] PERIOD_RESET = 10'd20;
  localparam logic [PPR_W-1:0] PPR_RESET    = 13'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR    = 1'b1;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic div_step;
    logic sign;
    logic sum;
    logic mul_new;
    logic mul_fb;
    logic acc;
    logic round;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== src/esrf_ifs.sv =====
// Valid/ready channel interfaces for the speed filter: sample in, speed out.
// Depends on esrf_pkg.
`timescale 1ns / 1ps

interface esrf_in_if #(
  parameter int CNT_W = esrf_pkg::COUNTER_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] counter_now;
  logic             forward;

  modport source (output valid, output counter_now, output forward, input ready);
  modport sink   (input valid, input counter_now, input forward, output ready);
endinterface

interface esrf_out_if;
  import esrf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RPM_W-1:0] rpm_raw;
  logic signed [RPM_W-1:0] rpm_filtered;

  modport source (output valid, output rpm_raw, output rpm_filtered, input ready);
  modport sink   (input valid, input rpm_raw, input rpm_filtered, output ready);
endinterface

// ===== src/esrf_ctrl.sv =====
// Sequencer for the speed filter: steps the datapath through scale, divide,
// sign and filter phases. Depends on esrf_pkg.
`timescale 1ns / 1ps

module esrf_ctrl #(
  parameter int COUNTER_BITS = esrf_pkg::COUNTER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  esrf_pkg::stat_t stat,
  output esrf_pkg::cmd_t  cmd
);
  import esrf_pkg::*;

  localparam int NUM_W = COUNTER_BITS - 2 + SCALE_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCALE   = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SIGN    = 4'd3;
  localparam logic [3:0] S_SUM     = 4'd4;
  localparam logic [3:0] S_MUL_NEW = 4'd5;
  localparam logic [3:0] S_MUL_FB  = 4'd6;
  localparam logic [3:0] S_ACC     = 4'd7;
  localparam logic [3:0] S_ROUND   = 4'd8;
  localparam logic [3:0] S_COMMIT  = 4'd9;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] count;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cmd.load_in  = (state == S_IDLE) && in_valid;
    cmd.scale    = (state == S_SCALE);
    cmd.div_step = (state == S_DIV);
    cmd.sign     = (state == S_SIGN);
    cmd.sum      = (state == S_SUM);
    cmd.mul_new  = (state == S_MUL_NEW);
    cmd.mul_fb   = (state == S_MUL_FB);
    cmd.acc      = (state == S_ACC);
    cmd.round    = (state == S_ROUND);
    cmd.commit   = (state == S_COMMIT) && stat.out_free;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_SCALE;
      S_SCALE:   state_next = S_DIV;
      S_DIV:     if (count == '0) state_next = S_SIGN;
      S_SIGN:    state_next = S_SUM;
      S_SUM:     state_next = S_MUL_NEW;
      S_MUL_NEW: state_next = S_MUL_FB;
      S_MUL_FB:  state_next = S_ACC;
      S_ACC:     state_next = S_ROUND;
      S_ROUND:   state_next = S_COMMIT;
      S_COMMIT:  if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCALE) begin
        count <= CNT_W'(NUM_W - 1);
      end else if (state == S_DIV) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/esrf_dp.sv =====
// Datapath of the speed filter: counter difference, scaling, restoring
// divider, shared filter multiplier and output register. Depends on esrf_pkg.
`timescale 1ns / 1ps

module esrf_dp #(
  parameter int COUNTER_BITS = esrf_pkg::COUNTER_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  esrf_pkg::cmd_t                         cmd,
  output esrf_pkg::stat_t                        stat,
  input  logic                                   cfg_write,
  input  logic [esrf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [esrf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [COUNTER_BITS-1:0]                counter_now,
  input  logic                                   forward,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [esrf_pkg::RPM_W-1:0]      rpm_raw,
  output logic signed [esrf_pkg::RPM_W-1:0]      rpm_filtered
);
  import esrf_pkg::*;

  localparam int EDGE_W = COUNTER_BITS - 2;
  localparam int NUM_W  = EDGE_W + SCALE_W;
  localparam int WIDE_W = 64;

  logic [PER_W-1:0]         period;
  logic [PPR_W-1:0]         ppr;
  logic [COUNTER_BITS-1:0]  last_count;
  logic                     fwd;
  logic [EDGE_W-1:0]        edges;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         rem;
  logic signed [RPM_W-1:0]  raw;
  logic signed [RPM_W-1:0]  last_rpm;
  logic signed [RPM_W-1:0]  smoothed;
  logic signed [RPM_W-1:0]  filt;
  logic signed [OPND_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [COUNTER_BITS-1:0]  diff;
  logic [PER_W-1:0]         per_eff;
  logic [PPR_W-1:0]         ppr_eff;
  logic [DEN_W+1:0]         trial;
  logic [WIDE_W-1:0]        quo_wide;
  logic [RPM_W-1:0]         mag;
  logic signed [OPND_W-1:0] mul_a;
  logic signed [COEF_W-1:0] mul_c;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;
  logic signed [RPM_W-1:0]  filt_sat;

  assign stat.out_free = !out_valid || out_ready;

  assign diff    = forward ? (counter_now - last_count) : (last_count - counter_now);
  assign per_eff = (period == '0) ? PER_W'(1) : period;
  assign ppr_eff = (ppr == '0) ? PPR_W'(1) : ppr;
  assign trial   = {1'b0, rem, num[NUM_W-1]} - {2'b00, den};

  assign quo_wide = WIDE_W'(num);
  assign mag      = (quo_wide > WIDE_W'(RPM_MAX)) ? RPM_MAX : quo_wide[RPM_W-1:0];

  // One multiplier serves both taps; the two raw taps share a coefficient.
  assign mul_a = cmd.mul_fb ? {smoothed[RPM_W-1], smoothed} : opnd;
  assign mul_c = cmd.mul_fb ? COEF_FB : COEF_NEW;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_c);

  assign rnd     = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
  assign shifted = SH_W'(rnd >>> FRAC_BITS);
  always_comb begin
    if (shifted > SH_W'(RPM_MAX)) begin
      filt_sat = RPM_MAX;
    end else if (shifted < SH_W'(RPM_MIN)) begin
      filt_sat = RPM_MIN;
    end else begin
      filt_sat = shifted[RPM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RESET;
      ppr        <= PPR_RESET;
      last_count <= '0;
      last_rpm   <= '0;
      smoothed   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PERIOD: period <= cfg_data[PER_W-1:0];
          CFG_PPR:    ppr    <= cfg_data;
          default:    ;
        endcase
      end
      if (cmd.load_in) begin
        last_count <= counter_now;
      end
      if (cmd.commit) begin
        last_rpm  <= raw;
        smoothed  <= filt;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fwd   <= forward;
      edges <= diff[COUNTER_BITS-1:2];
    end
    if (cmd.scale) begin
      num <= edges * SCALE;
      den <= DEN_W'(per_eff) * DEN_W'(ppr_eff);
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W-1:0];
        num <= {num[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-2:0], num[NUM_W-1]};
        num <= {num[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.sign) begin
      raw <= fwd ? $signed(mag) : -$signed(mag);
    end
    if (cmd.sum) begin
      opnd <= {raw[RPM_W-1], raw} + {last_rpm[RPM_W-1], last_rpm};
    end
    if (cmd.mul_new) begin
      prod <= mul_p;
    end
    if (cmd.mul_fb) begin
      acc  <= ACC_W'(prod);
      prod <= mul_p;
    end
    if (cmd.acc) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.round) begin
      filt <= filt_sat;
    end
    if (cmd.commit) begin
      rpm_raw      <= raw;
      rpm_filtered <= filt;
    end
  end

endmodule

// ===== src/encoder_speed_rpm_filter.sv =====
// Top level of the encoder speed filter: joins the sequencer and datapath.
// Depends on esrf_pkg, esrf_ifs, esrf_ctrl and esrf_dp.
`timescale 1ns / 1ps

// Usage
// The sample channel carries one beat per tick: the encoder counter reading
// (counter_now) and the direction flag (forward). The speed channel returns
// exactly one beat per sample: the raw speed and the low-pass filtered
// speed, both signed in 1/256 RPM and saturated to 40 bits.
// A sample is taken only while the sequencer is idle. The quotient is
// produced by a restoring divider that retires one bit per cycle, one for
// each of the N = COUNTER_BITS + 22 quotient bits. The sequencer then steps
// through sign, sum, both taps, accumulate, round and commit, and takes a
// new sample only after the previous one has been committed.
// The filter taps run through one shared multiplier, raw taps then feedback.
// Results sit in an output register, so the next sample is taken while the
// previous result still waits; if the receiver is still stalling when the
// next result is ready, the sequencer holds it and stops taking samples.
// Reset (synchronous, active high) clears the stored reading, raw and
// filtered speeds, drops any pending result and restores the sample period
// to 20 ms and the pulses per revolution to 100. Configuration writes are
// taken on any cycle but should only be made while no sample is in flight.

module encoder_speed_rpm_filter #(
  parameter int COUNTER_BITS = esrf_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  esrf_in_if.sink                         sample,
  esrf_out_if.source                      speed,
  input  logic                            cfg_write,
  input  logic [esrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esrf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import esrf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The sequencer owns the sample handshake; the datapath owns the result.
  esrf_ctrl #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Only the low COUNTER_BITS of the reading take part in the difference.
  esrf_dp #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .counter_now  (sample.counter_now[COUNTER_BITS-1:0]),
    .forward      (sample.forward),
    .out_valid    (speed.valid),
    .out_ready    (speed.ready),
    .rpm_raw      (speed.rpm_raw),
    .rpm_filtered (speed.rpm_filtered)
  );

endmodule

// ===== src/esrf_checker.sv =====
// Port-level checks for the encoder speed filter, bound to the top level.
// Depends on esrf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "encoder_speed_rpm_filter_macros.svh"

module esrf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [esrf_pkg::RPM_W-1:0]  rpm_raw,
  input logic signed [esrf_pkg::RPM_W-1:0]  rpm_filtered
);
  import esrf_pkg::*;

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // After reset the block is idle with nothing pending.
  `ESRF_ASSERT_RST(a_reset_idle, rst, in_ready && !out_valid)
  // Samples are worked one at a time.
  `ESRF_ASSERT_NEXT(a_one_in_flight, in_beat, !in_ready)
  // A result never appears in the cycle right after its sample.
  `ESRF_ASSERT_NEXT(a_no_early_result, in_beat, !$rose(out_valid))
  // A stalled result stays and holds its payload.
  `ESRF_ASSERT_NEXT(a_out_hold, out_stall,
                    out_valid && $stable(rpm_raw) && $stable(rpm_filtered))

endmodule

bind encoder_speed_rpm_filter esrf_checker u_esrf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (speed.valid),
  .out_ready    (speed.ready),
  .rpm_raw      (speed.rpm_raw),
  .rpm_filtered (speed.rpm_filtered)
);
